// File: design/packed_bcd_string_adder_defines.svh
// Assertion macros used by the adder top level.
`ifndef PACKED_BCD_STRING_ADDER_DEFINES_SVH
`define PACKED_BCD_STRING_ADDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBSA_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pbsa_pkg.sv
`timescale 1ns / 1ps

package pbsa_pkg;

    localparam int MAX_DIGITS = 32;
    localparam int ADDR_W     = $clog2(MAX_DIGITS);
    localparam int LEN_W      = $clog2(MAX_DIGITS + 1);
    localparam int SUM_DEPTH  = MAX_DIGITS + 1;
    localparam int SUM_AW     = $clog2(SUM_DEPTH);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 2);
    localparam int DIGIT_W    = 4;
    localparam int CMD_W      = 2;

    localparam logic [DIGIT_W-1:0] NIBBLE_END   = 4'hF;
    localparam logic [DIGIT_W-1:0] DIGIT_LIMIT  = 4'd10;
    localparam logic [DIGIT_W:0]   DECIMAL_BASE = 5'd10;

    localparam logic [CMD_W-1:0] CMD_LOAD_FIRST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_SECOND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADD         = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED      = 2'd3;

    typedef struct packed {
        logic push_hi;
        logic push_lo;
        logic add_start;
        logic add_step;
        logic fix;
        logic emit_rd;
        logic out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic add_done;
        logic out_free;
        logic emit_last;
    } ctl_status_t;

endpackage

// File: design/pbsa_ram.sv
`timescale 1ns / 1ps

module pbsa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/pbsa_ctrl.sv
`timescale 1ns / 1ps

module pbsa_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic [pbsa_pkg::CMD_W-1:0] s_tuser,
    output logic                       s_tready,
    input  pbsa_pkg::ctl_status_t      status,
    output pbsa_pkg::ctl_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_LOAD_LO = 3'd1;
    localparam logic [2:0] ST_ADD     = 3'd2;
    localparam logic [2:0] ST_FIX     = 3'd3;
    localparam logic [2:0] ST_EMIT_RD = 3'd4;
    localparam logic [2:0] ST_EMIT_LD = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    priority if (s_tuser == pbsa_pkg::CMD_LOAD_FIRST ||
                                 s_tuser == pbsa_pkg::CMD_LOAD_SECOND) begin
                        cmd.push_hi = 1'b1;
                        state_next  = ST_LOAD_LO;
                    end else if (s_tuser == pbsa_pkg::CMD_ADD) begin
                        cmd.add_start = 1'b1;
                        state_next    = ST_ADD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_LOAD_LO: begin
                cmd.push_lo = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_ADD: begin
                cmd.add_step = 1'b1;
                if (status.add_done) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                // The read data stays in the RAM output register until the
                // output stage can take it.
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = status.emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/pbsa_datapath.sv
`timescale 1ns / 1ps

module pbsa_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [7:0]                 s_tdata,
    input  logic [pbsa_pkg::CMD_W-1:0] s_tuser,
    input  pbsa_pkg::ctl_cmd_t         cmd,
    output pbsa_pkg::ctl_status_t      status,
    input  logic                       m_tready,
    output logic                       m_tvalid,
    output logic [7:0]                 m_tdata,
    output logic                       m_tlast,
    output logic                       m_tuser
);

    localparam int AW  = pbsa_pkg::ADDR_W;
    localparam int LW  = pbsa_pkg::LEN_W;
    localparam int SW  = pbsa_pkg::SUM_AW;
    localparam int CW  = pbsa_pkg::CNT_W;
    localparam int DW  = pbsa_pkg::DIGIT_W;

    // Operand bookkeeping.
    logic [LW-1:0] len1_reg, len1_next, len2_reg, len2_next;
    logic          closed1_reg, closed1_next, closed2_reg, closed2_next;
    logic          err_reg, err_next;
    logic          sel_reg, sel_next;
    logic [DW-1:0] lo_nib_reg, lo_nib_next;

    // Addition walk.
    logic [LW-1:0] n_reg, n_next;
    logic [LW-1:0] rd_idx_reg, rd_idx_next;
    logic [AW-1:0] wr_idx_reg, wr_idx_next;
    logic          pend_reg, pend_next;
    logic          a_ok_reg, a_ok_next, b_ok_reg, b_ok_next;
    logic          carry_reg, carry_next;

    // Emission.
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] k_reg, k_next;
    logic          sum_err_reg, sum_err_next;
    logic          m_valid_reg, m_valid_next;
    logic [DW-1:0] out_digit_reg, out_digit_next;
    logic          out_last_reg, out_last_next;
    logic          out_err_reg, out_err_next;

    // Push path.
    logic          push;
    logic [DW-1:0] nib;
    logic          sel;
    logic [LW-1:0] cur_len;
    logic          cur_closed;
    logic          is_end, is_bad, is_full, store_we;
    logic [DW-1:0] store_digit;

    // RAM ports.
    logic          we1, we2, re_ops;
    logic [AW-1:0] raddr1, raddr2;
    logic [DW-1:0] rdata1, rdata2;
    logic [LW-1:0] rpos1, rpos2;
    logic          sum_we, sum_re;
    logic [SW-1:0] sum_waddr, sum_raddr;
    logic [DW-1:0] sum_wdata, sum_rdata;
    logic [CW-1:0] emit_pos;

    logic          issue;
    logic [DW-1:0] a_dig, b_dig;
    logic [DW:0]   raw_sum;
    logic          ge_ten;
    logic [DW-1:0] step_digit;
    logic [DW:0]   step_diff;

    assign push = cmd.push_hi || cmd.push_lo;
    assign nib  = cmd.push_hi ? s_tdata[7:4] : lo_nib_reg;
    assign sel  = cmd.push_hi ? (s_tuser == pbsa_pkg::CMD_LOAD_SECOND) : sel_reg;

    assign cur_len     = sel ? len2_reg : len1_reg;
    assign cur_closed  = sel ? closed2_reg : closed1_reg;
    assign is_end      = (nib == pbsa_pkg::NIBBLE_END);
    assign is_bad      = !is_end && (nib >= pbsa_pkg::DIGIT_LIMIT);
    assign is_full     = (cur_len >= LW'(pbsa_pkg::MAX_DIGITS));
    assign store_we    = push && !cur_closed && !is_end && !is_full;
    assign store_digit = is_bad ? '0 : nib;
    assign we1         = store_we && !sel;
    assign we2         = store_we && sel;

    // Digits are stored most significant first, so digit i from the right
    // sits at position length - 1 - i.
    assign issue  = cmd.add_step && (rd_idx_reg != n_reg);
    assign re_ops = issue;
    assign rpos1  = len1_reg - LW'(1) - rd_idx_reg;
    assign rpos2  = len2_reg - LW'(1) - rd_idx_reg;
    assign raddr1 = rpos1[AW-1:0];
    assign raddr2 = rpos2[AW-1:0];

    assign a_dig      = a_ok_reg ? rdata1 : '0;
    assign b_dig      = b_ok_reg ? rdata2 : '0;
    assign raw_sum    = {1'b0, a_dig} + {1'b0, b_dig} + {{DW{1'b0}}, carry_reg};
    assign ge_ten     = (raw_sum >= pbsa_pkg::DECIMAL_BASE);
    assign step_diff  = raw_sum - pbsa_pkg::DECIMAL_BASE;
    assign step_digit = ge_ten ? step_diff[DW-1:0] : raw_sum[DW-1:0];

    always_comb begin
        if (cmd.fix) begin
            sum_we    = carry_reg || (n_reg == '0);
            sum_waddr = carry_reg ? SW'(n_reg) : '0;
            sum_wdata = carry_reg ? DW'(1) : '0;
        end else begin
            sum_we    = cmd.add_step && pend_reg;
            sum_waddr = SW'(wr_idx_reg);
            sum_wdata = step_digit;
        end
    end

    assign sum_re    = cmd.emit_rd;
    assign emit_pos  = count_reg - CW'(1) - k_reg;
    assign sum_raddr = emit_pos[SW-1:0];

    assign status.add_done  = (rd_idx_reg == n_reg);
    assign status.out_free  = !m_valid_reg || m_tready;
    assign status.emit_last = ((k_reg + CW'(1)) == count_reg);

    always_comb begin
        len1_next      = len1_reg;
        len2_next      = len2_reg;
        closed1_next   = closed1_reg;
        closed2_next   = closed2_reg;
        err_next       = err_reg;
        sel_next       = sel_reg;
        lo_nib_next    = lo_nib_reg;
        n_next         = n_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        pend_next      = pend_reg;
        a_ok_next      = a_ok_reg;
        b_ok_next      = b_ok_reg;
        carry_next     = carry_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        sum_err_next   = sum_err_reg;
        m_valid_next   = m_valid_reg;
        out_digit_next = out_digit_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;

        if (cmd.push_hi) begin
            sel_next    = sel;
            lo_nib_next = s_tdata[3:0];
        end

        if (push && !cur_closed) begin
            if (is_end) begin
                if (sel) begin
                    closed2_next = 1'b1;
                end else begin
                    closed1_next = 1'b1;
                end
            end else begin
                if (is_bad || is_full) begin
                    err_next = 1'b1;
                end
                if (!is_full) begin
                    if (sel) begin
                        len2_next = len2_reg + LW'(1);
                    end else begin
                        len1_next = len1_reg + LW'(1);
                    end
                end
            end
        end

        if (cmd.add_start) begin
            n_next      = (len1_reg > len2_reg) ? len1_reg : len2_reg;
            rd_idx_next = '0;
            pend_next   = 1'b0;
            carry_next  = 1'b0;
        end

        if (cmd.add_step) begin
            pend_next = issue;
            if (issue) begin
                a_ok_next   = (rd_idx_reg < len1_reg);
                b_ok_next   = (rd_idx_reg < len2_reg);
                wr_idx_next = rd_idx_reg[AW-1:0];
                rd_idx_next = rd_idx_reg + LW'(1);
            end
            if (pend_reg) begin
                carry_next = ge_ten;
            end
        end

        if (cmd.fix) begin
            if (carry_reg) begin
                count_next = CW'(n_reg) + CW'(1);
            end else if (n_reg == '0) begin
                count_next = CW'(1);
            end else begin
                count_next = CW'(n_reg);
            end
            k_next       = '0;
            sum_err_next = err_reg;
            len1_next    = '0;
            len2_next    = '0;
            closed1_next = 1'b0;
            closed2_next = 1'b0;
            err_next     = 1'b0;
        end

        if (cmd.out_load) begin
            m_valid_next   = 1'b1;
            out_digit_next = sum_rdata;
            out_last_next  = status.emit_last;
            out_err_next   = sum_err_reg;
            k_next         = k_reg + CW'(1);
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len1_reg    <= '0;
            len2_reg    <= '0;
            closed1_reg <= 1'b0;
            closed2_reg <= 1'b0;
            err_reg     <= 1'b0;
            n_reg       <= '0;
            rd_idx_reg  <= '0;
            pend_reg    <= 1'b0;
            carry_reg   <= 1'b0;
            count_reg   <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            len1_reg    <= len1_next;
            len2_reg    <= len2_next;
            closed1_reg <= closed1_next;
            closed2_reg <= closed2_next;
            err_reg     <= err_next;
            n_reg       <= n_next;
            rd_idx_reg  <= rd_idx_next;
            pend_reg    <= pend_next;
            carry_reg   <= carry_next;
            count_reg   <= count_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sel_reg       <= sel_next;
        lo_nib_reg    <= lo_nib_next;
        wr_idx_reg    <= wr_idx_next;
        a_ok_reg      <= a_ok_next;
        b_ok_reg      <= b_ok_next;
        sum_err_reg   <= sum_err_next;
        out_digit_reg <= out_digit_next;
        out_last_reg  <= out_last_next;
        out_err_reg   <= out_err_next;
    end

    pbsa_ram #(
        .WIDTH (DW),
        .DEPTH (pbsa_pkg::MAX_DIGITS)
    ) u_first_ram (
        .aclk  (aclk),
        .we    (we1),
        .waddr (cur_len[AW-1:0]),
        .wdata (store_digit),
        .re    (re_ops),
        .raddr (raddr1),
        .rdata (rdata1)
    );

    pbsa_ram #(
        .WIDTH (DW),
        .DEPTH (pbsa_pkg::MAX_DIGITS)
    ) u_second_ram (
        .aclk  (aclk),
        .we    (we2),
        .waddr (cur_len[AW-1:0]),
        .wdata (store_digit),
        .re    (re_ops),
        .raddr (raddr2),
        .rdata (rdata2)
    );

    pbsa_ram #(
        .WIDTH (DW),
        .DEPTH (pbsa_pkg::SUM_DEPTH)
    ) u_sum_ram (
        .aclk  (aclk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .re    (sum_re),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8 - DW){1'b0}}, out_digit_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

endmodule

// File: design/packed_bcd_string_adder.sv
// A load transaction stores the high nibble on acceptance and the low nibble in the next cycle.
// An add of n digits walks the operand RAMs one digit per cycle, then a fix step writes the carry.
// The sum is then read back from the sum RAM, most significant digit first, each read waiting
// until the output stage is free; input is ready again once the last digit is in that stage.
// Reset (aresetn, synchronous, active low) clears lengths, flags, the state and the output valid;
// the digit RAMs are not cleared, and data read from them is only used where it has been written.
`timescale 1ns / 1ps

`include "packed_bcd_string_adder_defines.svh"

module packed_bcd_string_adder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] operand_byte
    input  logic [1:0] s_axis_tuser,   // [1:0] cmd
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [3:0] sum_digit, [7:4] zero
    output logic       m_axis_tlast,
    output logic [0:0] m_axis_tuser    // [0] input_error
);

    pbsa_pkg::ctl_cmd_t    ctl_cmd;
    pbsa_pkg::ctl_status_t ctl_status;

    pbsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tuser  (s_axis_tuser),
        .s_tready (s_axis_tready),
        .status   (ctl_status),
        .cmd      (ctl_cmd)
    );

    pbsa_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .cmd      (ctl_cmd),
        .status   (ctl_status),
        .m_tready (m_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tdata  (m_axis_tdata),
        .m_tlast  (m_axis_tlast),
        .m_tuser  (m_axis_tuser[0])
    );

    `PBSA_ASSERT_IMPLY(a_cmd_exclusive, aclk, aresetn, 1'b1, $onehot0(ctl_cmd),
        "controller issued two commands at once")
    `PBSA_ASSERT_IMPLY(a_load_when_free, aclk, aresetn, ctl_cmd.out_load,
        (!m_axis_tvalid || m_axis_tready), "output stage overwritten while a digit was waiting")
    `PBSA_ASSERT_NEXT(a_busy_after_work, aclk, aresetn,
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser != pbsa_pkg::CMD_UNUSED)),
        !s_axis_tready, "input still ready while a transaction is in progress")
    `PBSA_ASSERT_IMPLY(a_digit_decimal, aclk, aresetn, m_axis_tvalid,
        ((m_axis_tdata[3:0] <= 4'd9) && (m_axis_tdata[7:4] == 4'd0)),
        "emitted digit is not decimal")

endmodule
